/* rtl/core/hcd_pkg.sv */
`default_nettype none

package hcd_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int LEVEL_W    = 20;
   localparam int HYST_W     = 20;
   localparam int PERIOD_W   = 32;
   localparam int TIME_W     = 57;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // level - prev*16 and cur - prev, with their magnitudes
   localparam int NUM_W     = 22;
   localparam int NUM_MAG_W = 21;
   localparam int DEN_W     = 17;
   localparam int DEN_MAG_W = 16;

   // level and hysteresis carry four fractional bits
   localparam int LEVEL_FRAC = 4;

   localparam int QUEUE_AW = 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LEVEL      = 2'd0,
      CSR_HYSTERESIS = 2'd1,
      CSR_PERIOD     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_SETUP,
      BK_MULTIPLY,
      BK_FINISH,
      BK_OUTPUT
   } back_state_type;

endpackage

`default_nettype wire

/* rtl/core/hcd_queue.sv */
`default_nettype none

module hcd_queue #(
   parameter int WIDTH = 64,
   parameter int AW    = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic      [WIDTH-1:0] pop_data
);

   localparam int DEPTH = 2 ** AW;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      push_ready = (count_ff != (AW+1)'(DEPTH));
      pop_valid  = (count_ff != '0);
      pop_data   = mem_ff[rd_ptr_ff];
      do_push    = push_valid & push_ready;
      do_pop     = pop_valid & pop_ready;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/hcd_front.sv */
`default_nettype none

module hcd_front #(
   parameter int INDEX_BITS = 24,
   parameter int ENTRY_W    = INDEX_BITS + 40
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   output logic                                    in_ready,
   input  wire logic signed [hcd_pkg::SAMPLE_W-1:0] sample,
   input  wire logic                               record_start,
   input  wire logic signed [hcd_pkg::LEVEL_W-1:0]  level_q4,
   input  wire logic        [hcd_pkg::HYST_W-1:0]   hysteresis_q4,
   output logic                                    push_valid,
   input  wire logic                               push_ready,
   output logic             [ENTRY_W-1:0]          push_data
);

   import hcd_pkg::*;

   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic                       above_ff, above_in;
   logic [INDEX_BITS-1:0]      idx_ff, idx_in;
   logic                       open_ff, open_in;

   logic                       accept;
   logic signed [LEVEL_W-1:0]  cur_x16;
   logic signed [22:0]         cur_x32, up_thr, dn_thr, lvl_x2;
   logic                       hy_nz, rise, fall;
   logic signed [NUM_W-1:0]    num;
   logic signed [DEN_W-1:0]    den;

   // previous sample scaled to the level's fixed point
   function automatic logic signed [LEVEL_W-1:0] cur_x16_prev();
      return {prev_ff, 4'b0000};
   endfunction

   always_comb begin
      in_ready = push_ready;
      accept   = in_valid & in_ready;

      cur_x16 = {sample, 4'b0000};
      cur_x32 = {{2{sample[SAMPLE_W-1]}}, sample, 5'b00000};
      lvl_x2  = {{2{level_q4[LEVEL_W-1]}}, level_q4, 1'b0};
      up_thr  = lvl_x2 + $signed({3'b000, hysteresis_q4});
      dn_thr  = lvl_x2 - $signed({3'b000, hysteresis_q4});
      hy_nz   = (hysteresis_q4 != '0);
      rise    = hy_nz & ~above_ff & (cur_x32 >= up_thr);
      fall    = hy_nz & above_ff & (cur_x32 <= dn_thr);

      num = NUM_W'(level_q4) - NUM_W'(cur_x16_prev());
      den = DEN_W'(sample) - DEN_W'(prev_ff);

      prev_in  = prev_ff;
      above_in = above_ff;
      idx_in   = idx_ff;
      open_in  = open_ff;
      push_valid = 1'b0;

      if (accept) begin
         if (record_start) begin
            prev_in  = sample;
            above_in = (cur_x16 > level_q4);
            idx_in   = '0;
            open_in  = 1'b1;
         end else if (open_ff) begin
            prev_in = sample;
            if (idx_ff != '1) begin
               idx_in = idx_ff + 1'b1;
            end
            if (rise || fall) begin
               above_in   = rise;
               push_valid = 1'b1;
            end
         end
      end

      push_data = {rise, den, num, idx_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         above_ff <= 1'b0;
         idx_ff   <= '0;
         open_ff  <= 1'b0;
      end else begin
         prev_ff  <= prev_in;
         above_ff <= above_in;
         idx_ff   <= idx_in;
         open_ff  <= open_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/hcd_back.sv */
`default_nettype none

module hcd_back #(
   parameter int INDEX_BITS    = 24,
   parameter int FRACTION_BITS = 16,
   parameter int ENTRY_W       = INDEX_BITS + 40
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              pop_valid,
   output logic                                   pop_ready,
   input  wire logic [ENTRY_W-1:0]                pop_data,
   input  wire logic [hcd_pkg::PERIOD_W-1:0]      sample_period,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [INDEX_BITS-1:0]                  crossing_index,
   output logic signed [FRACTION_BITS:0]          crossing_fraction,
   output logic signed [hcd_pkg::TIME_W-1:0]      crossing_time,
   output logic                                   rising
);

   import hcd_pkg::*;

   localparam int DW     = NUM_MAG_W + FRACTION_BITS - LEVEL_FRAC;
   localparam int XW     = INDEX_BITS + FRACTION_BITS + 1;
   localparam int PW     = XW + PERIOD_W + 1;
   localparam int MAXS   = (DW > XW) ? DW : XW;
   localparam int CNT_W  = $clog2(MAXS + 1);

   back_state_type state_ff, state_in;

   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [INDEX_BITS-1:0]     idx_ff;
   logic                      rising_ff, neg_ff, zden_ff;
   logic [DW-1:0]             dvd_ff;
   logic [DEN_MAG_W-1:0]      dvs_ff, rem_ff;
   logic signed [FRACTION_BITS:0] frac_ff;
   logic signed [PERIOD_W:0]  hi_ff;
   logic [XW-1:0]             lo_ff;

   // queue entry fields
   logic [INDEX_BITS-1:0]     e_idx;
   logic signed [NUM_W-1:0]   e_num;
   logic signed [DEN_W-1:0]   e_den;
   logic                      e_rise;
   logic [NUM_W-1:0]          num_mag;
   logic [DEN_W-1:0]          den_mag;

   // divider step
   logic [DEN_MAG_W:0]        rem_sh;
   logic                      q_bit;
   logic [DEN_MAG_W:0]        rem_sub;

   // fraction from quotient
   logic                      q_sat;
   logic signed [FRACTION_BITS:0] frac_pos, frac_neg, frac_val;
   logic signed [XW-1:0]      x_val;

   // multiplier step
   logic signed [PERIOD_W+1:0] addend, mul_sum;
   logic                       last_step;

   logic signed [PW-1:0]       prod, prod_sh;
   logic signed [TIME_W-1:0]   time_val;

   logic div_done, mul_done;

   always_comb begin
      {e_rise, e_den, e_num, e_idx} = pop_data;
      num_mag = e_num[NUM_W-1] ? NUM_W'(-e_num) : NUM_W'(e_num);
      den_mag = e_den[DEN_W-1] ? DEN_W'(-e_den) : DEN_W'(e_den);

      rem_sh  = {rem_ff, dvd_ff[DW-1]};
      q_bit   = (rem_sh >= {1'b0, dvs_ff});
      rem_sub = q_bit ? rem_sh - {1'b0, dvs_ff} : rem_sh;

      q_sat    = |dvd_ff[DW-1:FRACTION_BITS];
      frac_pos = q_sat ? {1'b0, {FRACTION_BITS{1'b1}}}
                       : {1'b0, dvd_ff[FRACTION_BITS-1:0]};
      frac_neg = q_sat ? {1'b1, {FRACTION_BITS{1'b0}}}
                       : -$signed({1'b0, dvd_ff[FRACTION_BITS-1:0]});
      frac_val = zden_ff ? '0 : (neg_ff ? frac_neg : frac_pos);
      // index plus the signed fraction, with FRACTION_BITS fractional bits
      x_val = $signed({1'b0, idx_ff, {FRACTION_BITS{1'b0}}}) + XW'(frac_ff);

      // sign bit of the multiplier carries negative weight
      last_step = (cnt_ff == CNT_W'(XW));
      addend    = '0;
      if (lo_ff[0]) begin
         addend = last_step ? -$signed({2'b00, sample_period})
                            : $signed({2'b00, sample_period});
      end
      mul_sum = {hi_ff[PERIOD_W], hi_ff} + addend;

      prod    = {hi_ff, lo_ff};
      prod_sh = prod >>> FRACTION_BITS;

      div_done = (cnt_ff == CNT_W'(DW - 1));
      mul_done = last_step;
   end

   generate
      if (PW >= TIME_W) begin : g_time_trunc
         assign time_val = prod_sh[TIME_W-1:0];
      end else begin : g_time_ext
         assign time_val = {{(TIME_W-PW){prod_sh[PW-1]}}, prod_sh};
      end
   endgenerate

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:     if (pop_valid) state_in = BK_DIVIDE;
         BK_DIVIDE:   if (div_done) state_in = BK_SETUP;
         BK_SETUP:    state_in = BK_MULTIPLY;
         BK_MULTIPLY: if (mul_done) state_in = BK_FINISH;
         BK_FINISH:   state_in = BK_OUTPUT;
         BK_OUTPUT:   if (out_ready) state_in = BK_IDLE;
         default:     state_in = BK_IDLE;
      endcase
   end

   // outputs and counter next value
   always_comb begin
      pop_ready = 1'b0;
      out_valid = 1'b0;
      cnt_in    = '0;
      case (state_ff)
         BK_IDLE:     pop_ready = 1'b1;
         BK_DIVIDE:   cnt_in = div_done ? '0 : cnt_ff + 1'b1;
         BK_SETUP:    cnt_in = '0;
         BK_MULTIPLY: cnt_in = mul_done ? '0 : cnt_ff + 1'b1;
         BK_FINISH:   cnt_in = '0;
         BK_OUTPUT:   out_valid = 1'b1;
         default:     cnt_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               idx_ff    <= e_idx;
               rising_ff <= e_rise;
               neg_ff    <= e_num[NUM_W-1] ^ e_den[DEN_W-1];
               zden_ff   <= (e_den == '0);
               dvd_ff    <= {num_mag[NUM_MAG_W-1:0],
                             {(FRACTION_BITS-LEVEL_FRAC){1'b0}}};
               dvs_ff    <= den_mag[DEN_MAG_W-1:0];
               rem_ff    <= '0;
            end
         end
         BK_DIVIDE: begin
            // quotient bits shift in as dividend bits shift out
            rem_ff <= rem_sub[DEN_MAG_W-1:0];
            dvd_ff <= {dvd_ff[DW-2:0], q_bit};
         end
         BK_SETUP: begin
            frac_ff <= frac_val;
         end
         BK_MULTIPLY: begin
            if (cnt_ff == '0) begin
               hi_ff <= '0;
               lo_ff <= x_val;
            end else begin
               hi_ff <= mul_sum[PERIOD_W+1:1];
               lo_ff <= {mul_sum[0], lo_ff[XW-1:1]};
            end
         end
         BK_FINISH: begin
            crossing_index    <= idx_ff;
            crossing_fraction <= frac_ff;
            crossing_time     <= time_val;
            rising            <= rising_ff;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/hysteresis_crossing_detector.sv */
// throughput: one sample per cycle while the four-entry crossing queue has room;
// each crossing holds the back end through a bit-serial divider for the fraction,
// then a bit-serial multiplier for the time
// reset (synchronous, active high) clears the CSRs, FSM state, record state and queue
`default_nettype none

module hysteresis_crossing_detector #(
   parameter int INDEX_BITS    = 24,
   parameter int FRACTION_BITS = 16,
   localparam int RSP_RAW = INDEX_BITS + FRACTION_BITS + 1 + hcd_pkg::TIME_W,
   localparam int RSP_W   = ((RSP_RAW + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [hcd_pkg::SAMPLE_W-1:0]      req_tdata,   // sample
   input  wire logic                              req_tuser,   // record_start
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // crossing_index, crossing_fraction, crossing_time, zero fill
   output logic [RSP_W-1:0]                       rsp_tdata,
   output logic                                   rsp_tuser,   // rising
   input  wire logic                              csr_we,
   input  wire logic [hcd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [hcd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import hcd_pkg::*;

   localparam int ENTRY_W = INDEX_BITS + NUM_W + DEN_W + 1;

   logic signed [LEVEL_W-1:0] level_ff;
   logic [HYST_W-1:0]         hyst_ff;
   logic [PERIOD_W-1:0]       period_ff;

   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   logic [INDEX_BITS-1:0]         crossing_index;
   logic signed [FRACTION_BITS:0] crossing_fraction;
   logic signed [TIME_W-1:0]      crossing_time;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         hyst_ff   <= '0;
         period_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LEVEL:      level_ff  <= csr_wdata[LEVEL_W-1:0];
            CSR_HYSTERESIS: hyst_ff   <= csr_wdata[HYST_W-1:0];
            CSR_PERIOD:     period_ff <= csr_wdata[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   hcd_front #(
      .INDEX_BITS (INDEX_BITS),
      .ENTRY_W    (ENTRY_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .sample        (req_tdata),
      .record_start  (req_tuser),
      .level_q4      (level_ff),
      .hysteresis_q4 (hyst_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   hcd_queue #(
      .WIDTH (ENTRY_W),
      .AW    (QUEUE_AW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   hcd_back #(
      .INDEX_BITS    (INDEX_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .ENTRY_W       (ENTRY_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .sample_period     (period_ff),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .crossing_index    (crossing_index),
      .crossing_fraction (crossing_fraction),
      .crossing_time     (crossing_time),
      .rising            (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'({crossing_time, crossing_fraction, crossing_index});

endmodule

`default_nettype wire
